// ===== hw/rtl/bmhq_pkg.sv =====
// Shared constants and codes for the binary min-heap queue unit.
`timescale 1ns / 1ps
package bmhq_pkg;

  localparam int unsigned DEFAULT_DEPTH = 64;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned CAP_W    = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

endpackage

// ===== hw/rtl/bmhq_if.sv =====
// Valid/ready channel interfaces for the request and result beats.
`timescale 1ns / 1ps
interface bmhq_in_if;
  import bmhq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic        [ACTION_W-1:0] action;
  logic signed [KEY_W-1:0]    key_value;

  modport source (output valid, action, key_value, input ready);
  modport sink   (input valid, action, key_value, output ready);
endinterface

interface bmhq_out_if;
  import bmhq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic        [STATUS_W-1:0] status;
  logic signed [KEY_W-1:0]    removed_value;
  logic signed [KEY_W-1:0]    min_value;
  logic        [COUNT_W-1:0]  heap_count;

  modport source (output valid, status, removed_value, min_value, heap_count, input ready);
  modport sink   (input valid, status, removed_value, min_value, heap_count, output ready);
endinterface

// ===== hw/rtl/binary_min_heap_queue_unit.sv =====
// Binary min-heap priority queue of signed keys, top level with sift sequencer.
//
// Requests arrive as beats on in_chan_i (action, key_value); each request
// gives exactly one result beat on out_chan_o (status, removed_value,
// min_value, heap_count). cfg_we_i/cfg_wdata_i write capacity_limit.
// The heap lives in one DEPTH x 32 array with one write and one registered
// read port; a single comparator serves every sift step.
// A query, a refused insert and an empty remove go straight to the result.
// An insert climbs level by level, reading the parent and then comparing;
// a remove loads the last entry into the root hole, then descends, reading
// the left child, comparing it while reading the right, then comparing the
// right. The pace is set by the memory read port and the shared comparator.
// in_chan_i.ready is high only while the sequencer is idle; one request is
// in work at a time. The result sits in an output register, so a new
// request is taken while an earlier result waits; if the receiver stalls,
// the next result holds in the sequencer until the register frees.
// Reset empties the heap (count 0) and sets capacity_limit to 64; the
// array itself is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module binary_min_heap_queue_unit #(
  parameter int unsigned DEPTH = bmhq_pkg::DEFAULT_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bmhq_pkg::CAP_W-1:0]    cfg_wdata_i,
  bmhq_in_if.sink                       in_chan_i,
  bmhq_out_if.source                    out_chan_o
);
  import bmhq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = AW + 2;
  localparam int unsigned LW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_UP_RD   = 8'b0000_0010,
    ST_UP_CMP  = 8'b0000_0100,
    ST_REM_LD  = 8'b0000_1000,
    ST_DN_RDL  = 8'b0001_0000,
    ST_DN_CMPL = 8'b0010_0000,
    ST_DN_CMPR = 8'b0100_0000,
    ST_RESP    = 8'b1000_0000
  } state_e;

  state_e                 state_q, state_d;
  logic [CW-1:0]          count_q, count_d;
  logic [CAP_W-1:0]       cap_q;
  logic                   out_valid_q, out_valid_d;

  logic [AW-1:0]          pos_q, pos_d;
  logic [KEY_W-1:0]       val_q, val_d;
  logic [KEY_W-1:0]       best_val_q, best_val_d;
  logic                   left_q, left_d;
  logic [KEY_W-1:0]       root_q, root_d;
  logic [STATUS_W-1:0]    status_q, status_d;
  logic [KEY_W-1:0]       rem_q, rem_d;

  logic [STATUS_W-1:0]    o_status_q, o_status_d;
  logic [KEY_W-1:0]       o_rem_q, o_rem_d;
  logic [KEY_W-1:0]       o_min_q, o_min_d;
  logic [COUNT_W-1:0]     o_cnt_q, o_cnt_d;

  logic [KEY_W-1:0]       mem [DEPTH];
  logic [KEY_W-1:0]       rd_q;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [KEY_W-1:0]       mem_wd;

  logic [KEY_W-1:0]       cmp_a, cmp_b;
  logic                   cmp_lt;

  logic                   in_fire;
  logic                   full;
  logic [CW-1:0]          cnt_m1;
  logic [XW-1:0]          l_idx, r_idx;
  logic                   l_ok, r_ok;
  logic [AW-1:0]          parent;

  bmhq_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .lt_o (cmp_lt)
  );

  assign in_chan_i.ready = (state_q == ST_IDLE);
  assign in_fire         = in_chan_i.valid && in_chan_i.ready;

  assign full   = (count_q == CW'(DEPTH)) || (LW'(count_q) >= LW'(cap_q));
  assign cnt_m1 = count_q - 1'b1;
  assign l_idx  = {1'b0, pos_q, 1'b1};
  assign r_idx  = l_idx + 1'b1;
  assign l_ok   = (l_idx < XW'(count_q));
  assign r_ok   = (r_idx < XW'(count_q));
  assign parent = AW'((pos_q - 1'b1) >> 1);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    pos_d       = pos_q;
    val_d       = val_q;
    best_val_d  = best_val_q;
    left_d      = left_q;
    status_d    = status_q;
    rem_d       = rem_q;
    o_status_d  = o_status_q;
    o_rem_d     = o_rem_q;
    o_min_d     = o_min_q;
    o_cnt_d     = o_cnt_q;
    mem_we      = 1'b0;
    mem_wa      = pos_q;
    mem_wd      = val_q;
    rd_en       = 1'b0;
    rd_addr     = l_idx[AW-1:0];
    cmp_a       = rd_q;
    cmp_b       = val_q;

    if (out_valid_q && out_chan_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          status_d = STAT_OK;
          rem_d    = '0;
          state_d  = ST_RESP;
          unique case (in_chan_i.action)
            ACT_INSERT: begin
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                val_d   = in_chan_i.key_value;
                pos_d   = count_q[AW-1:0];
                count_d = count_q + 1'b1;
                state_d = ST_UP_RD;
              end
            end
            ACT_REMOVE: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                rem_d   = root_q;
                count_d = cnt_m1;
                rd_en   = 1'b1;
                rd_addr = cnt_m1[AW-1:0];
                state_d = ST_REM_LD;
              end
            end
            default: begin
              // query and the unused code change nothing
            end
          endcase
        end
      end
      ST_UP_RD: begin
        if (pos_q == '0) begin
          mem_we  = 1'b1;
          state_d = ST_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent;
          state_d = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        cmp_a  = val_q;
        cmp_b  = rd_q;
        mem_we = 1'b1;
        if (cmp_lt) begin
          // parent moves down into the hole
          mem_wd  = rd_q;
          pos_d   = parent;
          state_d = ST_UP_RD;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_REM_LD: begin
        val_d = rd_q;
        if (count_q == '0) begin
          state_d = ST_RESP;
        end else begin
          pos_d   = '0;
          state_d = ST_DN_RDL;
        end
      end
      ST_DN_RDL: begin
        if (l_ok) begin
          rd_en   = 1'b1;
          rd_addr = l_idx[AW-1:0];
          state_d = ST_DN_CMPL;
        end else begin
          mem_we  = 1'b1;
          state_d = ST_RESP;
        end
      end
      ST_DN_CMPL: begin
        cmp_a      = rd_q;
        cmp_b      = val_q;
        left_d     = cmp_lt;
        best_val_d = cmp_lt ? rd_q : val_q;
        if (r_ok) begin
          rd_en   = 1'b1;
          rd_addr = r_idx[AW-1:0];
        end
        state_d = ST_DN_CMPR;
      end
      ST_DN_CMPR: begin
        cmp_a  = rd_q;
        cmp_b  = best_val_q;
        mem_we = 1'b1;
        if (r_ok && cmp_lt) begin
          mem_wd  = rd_q;
          pos_d   = r_idx[AW-1:0];
          state_d = ST_DN_RDL;
        end else if (left_q) begin
          // left child wins ties
          mem_wd  = best_val_q;
          pos_d   = l_idx[AW-1:0];
          state_d = ST_DN_RDL;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_q || out_chan_o.ready) begin
          out_valid_d = 1'b1;
          o_status_d  = status_q;
          o_rem_d     = rem_q;
          o_min_d     = (count_q == '0) ? '0 : root_q;
          o_cnt_d     = COUNT_W'(count_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // shadow of entry 0 so the minimum is always at hand
  always_comb begin
    root_d = root_q;
    if (mem_we && (mem_wa == '0)) begin
      root_d = mem_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    val_q      <= val_d;
    best_val_q <= best_val_d;
    left_q     <= left_d;
    root_q     <= root_d;
    status_q   <= status_d;
    rem_q      <= rem_d;
    o_status_q <= o_status_d;
    o_rem_q    <= o_rem_d;
    o_min_q    <= o_min_d;
    o_cnt_q    <= o_cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign out_chan_o.valid         = out_valid_q;
  assign out_chan_o.status        = o_status_q;
  assign out_chan_o.removed_value = o_rem_q;
  assign out_chan_o.min_value     = o_min_q;
  assign out_chan_o.heap_count    = o_cnt_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("heap count above depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_chan_i.action == ACT_INSERT) && !full)
      |=> (count_q == $past(count_q) + 1'b1))
    else $error("accepted insert did not grow the heap");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_chan_i.action == ACT_REMOVE) && (count_q != '0))
      |=> (count_q == $past(count_q) - 1'b1))
    else $error("remove did not shrink the heap");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CW'(mem_wa) < count_q))
    else $error("heap write beyond live entries");
`endif

endmodule

// ===== hw/rtl/bmhq_cmp.sv =====
// Shared signed key comparator used by every sift step.
`timescale 1ns / 1ps
module bmhq_cmp (
  input  logic signed [bmhq_pkg::KEY_W-1:0] a_i,
  input  logic signed [bmhq_pkg::KEY_W-1:0] b_i,
  output logic                              lt_o
);
  import bmhq_pkg::*;

  assign lt_o = (a_i < b_i);

endmodule

// ===== tb/sv/bmhq_result_checker.sv =====
// Shadow heap that predicts every result beat of the heap queue and compares it.
`timescale 1ns / 1ps
module bmhq_result_checker
  import bmhq_pkg::*;
#(
  parameter int unsigned DEPTH = DEFAULT_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CAP_W-1:0]        cfg_wdata_i,
  input  logic                    req_valid_i,
  input  logic                    req_ready_i,
  input  logic [ACTION_W-1:0]     req_action_i,
  input  logic signed [KEY_W-1:0] req_key_i,
  input  logic                    rsp_valid_i,
  input  logic                    rsp_ready_i,
  input  logic [STATUS_W-1:0]     rsp_status_i,
  input  logic signed [KEY_W-1:0] rsp_removed_i,
  input  logic signed [KEY_W-1:0] rsp_min_i,
  input  logic [COUNT_W-1:0]      rsp_count_i,
  output int unsigned             fail_count_o,
  output int unsigned             pending_o
);

  typedef struct {
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] removed_value;
    logic signed [KEY_W-1:0] min_value;
    logic [COUNT_W-1:0]      heap_count;
  } heap_result_t;

  logic signed [KEY_W-1:0] shadow_keys [DEPTH];
  int unsigned             shadow_count;
  logic [CAP_W-1:0]        shadow_cap;
  heap_result_t            owed_results [$];
  int unsigned             mismatch_total = 0;
  int unsigned             beat_idx = 0;

  task automatic report_mismatch(input string line);
    $display("%0t ns mismatch: %s", $time, line);
    mismatch_total++;
  endtask

  // four-state compare so an unknown field counts as a mismatch
  task automatic check_field(input string what, input logic signed [63:0] got,
                             input logic signed [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("beat %0d %s got %0d, expected %0d", beat_idx, what, got, want));
    end
  endtask

  task automatic swap_keys(input int unsigned a, input int unsigned b);
    logic signed [KEY_W-1:0] held;
    held           = shadow_keys[a];
    shadow_keys[a] = shadow_keys[b];
    shadow_keys[b] = held;
  endtask

  // Applies one request to the shadow heap and returns the beat it must produce.
  task automatic apply_heap_action(input logic [ACTION_W-1:0] act,
                                   input logic signed [KEY_W-1:0] key,
                                   output heap_result_t res);
    int unsigned usable;
    int unsigned pos;
    int unsigned up;
    int unsigned best;
    int unsigned lc;
    int unsigned rc;
    usable            = (shadow_cap < DEPTH) ? shadow_cap : DEPTH;
    res.status        = STAT_OK;
    res.removed_value = '0;
    if (act == ACT_INSERT) begin
      if (shadow_count >= usable) begin
        res.status = STAT_FULL;
      end else begin
        pos              = shadow_count;
        shadow_keys[pos] = key;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(shadow_keys[pos] < shadow_keys[up])) break;
          swap_keys(pos, up);
          pos = up;
        end
        shadow_count++;
      end
    end else if (act == ACT_REMOVE) begin
      if (shadow_count == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.removed_value = shadow_keys[0];
        shadow_keys[0]    = shadow_keys[shadow_count-1];
        shadow_count--;
        pos = 0;
        forever begin
          best = pos;
          lc   = 2 * pos + 1;
          rc   = 2 * pos + 2;
          // left child keeps a tie: only a strictly smaller right child wins
          if (lc < shadow_count && shadow_keys[lc] < shadow_keys[best]) best = lc;
          if (rc < shadow_count && shadow_keys[rc] < shadow_keys[best]) best = rc;
          if (best == pos) break;
          swap_keys(pos, best);
          pos = best;
        end
      end
    end
    res.min_value  = (shadow_count > 0) ? shadow_keys[0] : '0;
    res.heap_count = shadow_count[COUNT_W-1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      shadow_cap   = CAP_RESET;
      owed_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) shadow_cap = cfg_wdata_i;
      if (rsp_valid_i && rsp_ready_i) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("beat %0d arrived with nothing outstanding", beat_idx));
        end else begin
          want = owed_results.pop_front();
          check_field("status", rsp_status_i, want.status);
          check_field("removed_value", rsp_removed_i, want.removed_value);
          check_field("min_value", rsp_min_i, want.min_value);
          check_field("heap_count", rsp_count_i, want.heap_count);
        end
        beat_idx++;
      end
      if (req_valid_i && req_ready_i) begin
        apply_heap_action(req_action_i, req_key_i, want);
        owed_results.push_back(want);
      end
      pending_o <= owed_results.size();
    end
    fail_count_o <= mismatch_total;
  end

endmodule

// ===== tb/sv/tb_binary_min_heap_queue_unit.sv =====
// Top of the heap queue testbench: clock, reset, request and capacity stimulus, verdict.
`timescale 1ns / 1ps
module tb_binary_min_heap_queue_unit;
  import bmhq_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;  // decoded as a query
  localparam int unsigned PHASE_BEATS = 155;
  localparam int unsigned NUM_PHASES  = 12;
  localparam int unsigned TAIL_CYCLES = 40;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i;
  logic [CAP_W-1:0] cfg_wdata_i;
  bit               calm_tail = 1'b0;
  int unsigned      mismatch_count;
  int unsigned      results_owed;

  bmhq_in_if  in_ch ();
  bmhq_out_if out_ch ();

  binary_min_heap_queue_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_chan_i  (in_ch),
    .out_chan_o (out_ch)
  );

  bmhq_result_checker u_shadow (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_valid_i  (in_ch.valid),
    .req_ready_i  (in_ch.ready),
    .req_action_i (in_ch.action),
    .req_key_i    (in_ch.key_value),
    .rsp_valid_i  (out_ch.valid),
    .rsp_ready_i  (out_ch.ready),
    .rsp_status_i (out_ch.status),
    .rsp_removed_i(out_ch.removed_value),
    .rsp_min_i    (out_ch.min_value),
    .rsp_count_i  (out_ch.heap_count),
    .fail_count_o (mismatch_count),
    .pending_o    (results_owed)
  );

  always #4 clk_i = ~clk_i;

  task automatic send_request(input logic [ACTION_W-1:0] act,
                              input logic signed [KEY_W-1:0] key);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.key_value <= key;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Capacity changes only with the heap unit drained and idle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (results_owed != 0);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 5))
      3:       return $signed($urandom_range(0, 8)) - 4;  // dense ties
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7fffffff;
          1:       return 32'sh80000000;
          2:       return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      5:       return $urandom_range(0, 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ACTION_W-1:0] pick_action(input int unsigned insert_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) return ACT_INSERT;
    if (roll < 95) return ACT_REMOVE;
    if (roll < 98) return ACT_QUERY;
    return ACT_SPARE;
  endfunction

  initial begin
    logic [CAP_W-1:0] cap_plan [NUM_PHASES];
    int unsigned      bias_plan [NUM_PHASES];
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_QUERY;
    in_ch.key_value <= '0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    cap_plan  = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd64, 7'd9, 7'd64, 7'd2, 7'd100, 7'd64, 7'd33,
                  7'd64};
    bias_plan = '{75, 55, 30, 70, 80, 60, 50, 65, 75, 35, 70, 50};
    cap_plan[6] = CAP_W'($urandom_range(1, 64));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty heap, queries, extreme keys, ties, alternating bit patterns
    send_request(ACT_REMOVE, 32'sh0);
    send_request(ACT_QUERY, 32'sh1234);
    send_request(ACT_SPARE, -32'sd1);
    send_request(ACT_INSERT, 32'sh7fffffff);
    send_request(ACT_INSERT, 32'sh80000000);
    send_request(ACT_INSERT, 32'sh0);
    send_request(ACT_INSERT, -32'sd1);
    send_request(ACT_INSERT, 32'sd5);
    send_request(ACT_INSERT, 32'sd5);
    send_request(ACT_INSERT, 32'sh55555555);
    send_request(ACT_INSERT, 32'shaaaaaaaa);
    repeat (4) send_request(ACT_REMOVE, 32'sh0);

    // capacity dropped below the count, then to zero
    write_capacity(7'd2);
    send_request(ACT_INSERT, 32'sd7);
    send_request(ACT_REMOVE, 32'sh0);
    send_request(ACT_REMOVE, 32'sh0);
    send_request(ACT_INSERT, 32'sd7);
    write_capacity(7'd0);
    send_request(ACT_INSERT, 32'sd9);
    repeat (3) send_request(ACT_REMOVE, 32'sh0);

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase >= NUM_PHASES - 2) calm_tail = 1'b1;
      write_capacity(cap_plan[phase]);
      repeat (PHASE_BEATS) send_request(pick_action(bias_plan[phase]), pick_key());
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (results_owed != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result-side backpressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
